// ----- rtl/lkvc_pkg.sv -----
// Shared types and constants for the LRU key-value cache.
// Holds the controller state encoding and the command and status words
// exchanged between controller and datapath. No dependencies.
`default_nettype none

package lkvc_pkg;

   localparam int DEF_ENTRIES    = 16;
   localparam int DEF_KEY_BITS   = 16;
   localparam int DEF_VALUE_BITS = 32;

   localparam int              CFG_BITS  = 5;
   localparam logic [CFG_BITS-1:0] CAP_RESET = 5'd16;

   localparam logic REQ_GET = 1'b0;
   localparam logic REQ_PUT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_SWEEP
   } state_type;

   typedef enum logic [1:0] {
      SEL_HIT,
      SEL_FREE,
      SEL_LRU
   } slot_sel_type;

   typedef struct packed {
      logic         start;
      logic         scan;
      logic         sweep_init;
      logic         sweep;
      logic         rsp_load;
      logic         wr_key;
      logic         wr_value;
      logic         set_valid;
      logic         age_all;
      slot_sel_type slot_sel;
   } cmd_type;

   typedef struct packed {
      logic is_put;
      logic hit;
      logic room;
      logic rsp_free;
      logic done;
   } status_type;

endpackage

`default_nettype wire

// ----- rtl/lru_key_value_cache_unit.sv -----
// Top level of the fully associative LRU key-value cache.
// Joins lkvc_ctrl and lkvc_datapath; depends on lkvc_pkg.
//
//   channel   direction  handshake                 payload
//   req_      in         req_valid / req_stall     req_type, req_key, req_value
//   rsp_      out        rsp_valid / rsp_stall     rsp_found, rsp_read_value
//   csr_      in         csr_wr_en                 csr_wr_data (capacity)
//
// A request is taken only in idle. A get that misses scans the key memory
// through its registered read port, decides and returns to idle; every
// other request adds a rank sweep over all entries before idle. Reset is
// synchronous and clears valid bits, occupancy and the capacity register
// (back to 16); the memories need no clearing pass.
// A stalled response word holds in its register; the next request is still
// taken and scanned, and only its response waits for the register to free.
`default_nettype none

module lru_key_value_cache_unit
   import lkvc_pkg::*;
#(
   parameter int ENTRIES    = DEF_ENTRIES,
   parameter int KEY_BITS   = DEF_KEY_BITS,
   parameter int VALUE_BITS = DEF_VALUE_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_type,
   input  wire logic [KEY_BITS-1:0]   req_key,
   input  wire logic [VALUE_BITS-1:0] req_value,

   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_found,
   output logic [VALUE_BITS-1:0]      rsp_read_value,

   input  wire logic                  csr_wr_en,
   input  wire logic [CFG_BITS-1:0]   csr_wr_data
);

   // command word down, status word up; nothing else crosses
   cmd_type    cmd;
   status_type sts;

   lkvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   lkvc_datapath #(
      .ENTRIES    (ENTRIES),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_type       (req_type),
      .req_key        (req_key),
      .req_value      (req_value),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_found      (rsp_found),
      .rsp_read_value (rsp_read_value)
   );

endmodule

`default_nettype wire

// ----- rtl/lkvc_ctrl.sv -----
// Controller state machine for the LRU key-value cache.
// Sequences scan, decision and rank sweep; depends on lkvc_pkg.
`default_nettype none

module lkvc_ctrl
   import lkvc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   output cmd_type         cmd,
   input  wire status_type sts
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!sts.is_put) begin
               // hold until the response register can take the word
               if (sts.rsp_free) begin
                  cmd.rsp_load = 1'b1;
                  if (sts.hit) begin
                     cmd.slot_sel   = SEL_HIT;
                     cmd.sweep_init = 1'b1;
                     state_in       = ST_SWEEP;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end else begin
               cmd.wr_value   = 1'b1;
               cmd.sweep_init = 1'b1;
               state_in       = ST_SWEEP;
               if (sts.hit) begin
                  cmd.slot_sel = SEL_HIT;
               end else if (sts.room) begin
                  cmd.slot_sel  = SEL_FREE;
                  cmd.wr_key    = 1'b1;
                  cmd.set_valid = 1'b1;
                  cmd.age_all   = 1'b1;
               end else begin
                  cmd.slot_sel = SEL_LRU;
                  cmd.wr_key   = 1'b1;
               end
            end
         end
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (sts.done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/lkvc_datapath.sv -----
// Datapath for the LRU key-value cache: key, value and rank memories,
// valid bits, scan trackers, capacity register and response register.
// Depends on lkvc_pkg; driven by lkvc_ctrl.
`default_nettype none

module lkvc_datapath
   import lkvc_pkg::*;
#(
   parameter int ENTRIES    = DEF_ENTRIES,
   parameter int KEY_BITS   = DEF_KEY_BITS,
   parameter int VALUE_BITS = DEF_VALUE_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output status_type                 sts,
   input  wire logic                  req_type,
   input  wire logic [KEY_BITS-1:0]   req_key,
   input  wire logic [VALUE_BITS-1:0] req_value,
   input  wire logic                  csr_wr_en,
   input  wire logic [CFG_BITS-1:0]   csr_wr_data,
   input  wire logic                  rsp_stall,
   output logic                       rsp_valid,
   output logic                       rsp_found,
   output logic [VALUE_BITS-1:0]      rsp_read_value
);

   localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_BITS = $clog2(ENTRIES + 1);
   localparam int CMP_BITS = (CNT_BITS > CFG_BITS) ? CNT_BITS : CFG_BITS;
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(ENTRIES - 1);
   localparam logic [CNT_BITS-1:0] CNT_END  = CNT_BITS'(ENTRIES);

   // storage
   logic [KEY_BITS-1:0]   key_mem   [ENTRIES];
   logic [VALUE_BITS-1:0] value_mem [ENTRIES];
   logic [IDX_BITS-1:0]   rank_mem  [ENTRIES];

   logic [KEY_BITS-1:0]   key_rd_ff;
   logic [VALUE_BITS-1:0] value_rd_ff;
   logic [IDX_BITS-1:0]   rank_rd_ff;

   // control registers
   logic [ENTRIES-1:0]  valid_ff,    valid_in;
   logic [CNT_BITS-1:0] occ_ff,      occ_in;
   logic [CFG_BITS-1:0] cap_ff,      cap_in;
   logic [CNT_BITS-1:0] cnt_ff,      cnt_in;
   logic                pipe_vld_ff, pipe_vld_in;
   logic                hit_ff,      hit_in;
   logic                free_ff,     free_in;
   logic                lru_ff,      lru_in;
   logic                age_ff,      age_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic                  type_ff,       type_in;
   logic [KEY_BITS-1:0]   key_ff,        key_in;
   logic [VALUE_BITS-1:0] value_ff,      value_in;
   logic [IDX_BITS-1:0]   pipe_idx_ff,   pipe_idx_in;
   logic [IDX_BITS-1:0]   hit_slot_ff,   hit_slot_in;
   logic [IDX_BITS-1:0]   hit_rank_ff,   hit_rank_in;
   logic [VALUE_BITS-1:0] hit_value_ff,  hit_value_in;
   logic [IDX_BITS-1:0]   free_slot_ff,  free_slot_in;
   logic [IDX_BITS-1:0]   lru_slot_ff,   lru_slot_in;
   logic [IDX_BITS-1:0]   lru_rank_ff,   lru_rank_in;
   logic [IDX_BITS-1:0]   tgt_slot_ff,   tgt_slot_in;
   logic [IDX_BITS-1:0]   tgt_rank_ff,   tgt_rank_in;
   logic                  found_ff,      found_in;
   logic [VALUE_BITS-1:0] rd_value_ff,   rd_value_in;

   logic                  issue;
   logic [IDX_BITS-1:0]   rd_addr;
   logic [IDX_BITS-1:0]   wr_slot;
   logic [IDX_BITS-1:0]   sel_rank;
   logic                  rank_we;
   logic [IDX_BITS-1:0]   rank_new;
   logic                  pipe_entry_vld;
   logic [CFG_BITS-1:0]   cap_eff;
   logic                  occ_lt_cap;
   logic                  rsp_free;

   assign issue          = (cmd.scan || cmd.sweep) && (cnt_ff < CNT_END);
   assign rd_addr        = cnt_ff[IDX_BITS-1:0];
   assign pipe_entry_vld = valid_ff[pipe_idx_ff];
   assign rank_we        = cmd.sweep && pipe_vld_ff;
   assign rsp_free       = !rsp_valid_ff || !rsp_stall;

   // zero capacity counts as one; saturation comes from the ENTRIES check
   assign cap_eff    = (cap_ff == '0) ? CFG_BITS'(1) : cap_ff;
   assign occ_lt_cap = (CMP_BITS'(occ_ff) < CMP_BITS'(cap_eff)) && (occ_ff < CNT_END);

   always_comb begin
      case (cmd.slot_sel)
         SEL_HIT:  wr_slot = hit_slot_ff;
         SEL_FREE: wr_slot = free_slot_ff;
         SEL_LRU:  wr_slot = lru_slot_ff;
         default:  wr_slot = hit_slot_ff;
      endcase
      sel_rank = (cmd.slot_sel == SEL_LRU) ? lru_rank_ff : hit_rank_ff;
   end

   // promote the target to most recent; age the entries that were ahead of it, or every valid entry on an insert
   always_comb begin
      if (pipe_idx_ff == tgt_slot_ff) begin
         rank_new = '0;
      end else if (pipe_entry_vld && (age_ff || (rank_rd_ff < tgt_rank_ff))) begin
         rank_new = rank_rd_ff + IDX_BITS'(1);
      end else begin
         rank_new = rank_rd_ff;
      end
   end

   always_comb begin
      valid_in     = valid_ff;
      occ_in       = occ_ff;
      cap_in       = csr_wr_en ? csr_wr_data : cap_ff;
      cnt_in       = cnt_ff;
      pipe_vld_in  = issue;
      pipe_idx_in  = issue ? rd_addr : pipe_idx_ff;
      hit_in       = hit_ff;
      free_in      = free_ff;
      lru_in       = lru_ff;
      age_in       = age_ff;
      type_in      = type_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      hit_slot_in  = hit_slot_ff;
      hit_rank_in  = hit_rank_ff;
      hit_value_in = hit_value_ff;
      free_slot_in = free_slot_ff;
      lru_slot_in  = lru_slot_ff;
      lru_rank_in  = lru_rank_ff;
      tgt_slot_in  = tgt_slot_ff;
      tgt_rank_in  = tgt_rank_ff;
      found_in     = found_ff;
      rd_value_in  = rd_value_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (issue) begin
         cnt_in = cnt_ff + CNT_BITS'(1);
      end

      if (cmd.start) begin
         type_in     = req_type;
         key_in      = req_key;
         value_in    = req_value;
         cnt_in      = '0;
         pipe_vld_in = 1'b0;
         hit_in      = 1'b0;
         free_in     = 1'b0;
         lru_in      = 1'b0;
      end

      if (cmd.scan && pipe_vld_ff) begin
         if (!hit_ff && pipe_entry_vld && (key_rd_ff == key_ff)) begin
            hit_in       = 1'b1;
            hit_slot_in  = pipe_idx_ff;
            hit_rank_in  = rank_rd_ff;
            hit_value_in = value_rd_ff;
         end
         if (!free_ff && !pipe_entry_vld) begin
            free_in      = 1'b1;
            free_slot_in = pipe_idx_ff;
         end
         // later slot wins a tie, as the oldest is searched with >=
         if (pipe_entry_vld && (!lru_ff || (rank_rd_ff >= lru_rank_ff))) begin
            lru_in      = 1'b1;
            lru_slot_in = pipe_idx_ff;
            lru_rank_in = rank_rd_ff;
         end
      end

      if (cmd.sweep_init) begin
         cnt_in      = '0;
         pipe_vld_in = 1'b0;
         tgt_slot_in = wr_slot;
         tgt_rank_in = sel_rank;
         age_in      = cmd.age_all;
      end

      if (cmd.set_valid) begin
         valid_in[wr_slot] = 1'b1;
         occ_in            = occ_ff + CNT_BITS'(1);
      end

      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         found_in     = hit_ff;
         rd_value_in  = hit_ff ? hit_value_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         occ_ff       <= '0;
         cap_ff       <= CAP_RESET;
         cnt_ff       <= '0;
         pipe_vld_ff  <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         lru_ff       <= 1'b0;
         age_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         occ_ff       <= occ_in;
         cap_ff       <= cap_in;
         cnt_ff       <= cnt_in;
         pipe_vld_ff  <= pipe_vld_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         lru_ff       <= lru_in;
         age_ff       <= age_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff      <= type_in;
      key_ff       <= key_in;
      value_ff     <= value_in;
      pipe_idx_ff  <= pipe_idx_in;
      hit_slot_ff  <= hit_slot_in;
      hit_rank_ff  <= hit_rank_in;
      hit_value_ff <= hit_value_in;
      free_slot_ff <= free_slot_in;
      lru_slot_ff  <= lru_slot_in;
      lru_rank_ff  <= lru_rank_in;
      tgt_slot_ff  <= tgt_slot_in;
      tgt_rank_ff  <= tgt_rank_in;
      found_ff     <= found_in;
      rd_value_ff  <= rd_value_in;
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         key_rd_ff   <= key_mem[rd_addr];
         value_rd_ff <= value_mem[rd_addr];
         rank_rd_ff  <= rank_mem[rd_addr];
      end
      if (cmd.wr_key) begin
         key_mem[wr_slot] <= key_ff;
      end
      if (cmd.wr_value) begin
         value_mem[wr_slot] <= value_ff;
      end
      if (rank_we) begin
         rank_mem[pipe_idx_ff] <= rank_new;
      end
   end

   assign sts.is_put   = (type_ff == REQ_PUT);
   assign sts.hit      = hit_ff;
   assign sts.room     = free_ff && occ_lt_cap;
   assign sts.rsp_free = rsp_free;
   assign sts.done     = pipe_vld_ff && (pipe_idx_ff == LAST_IDX);

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = found_ff;
   assign rsp_read_value = rd_value_ff;

`ifndef SYNTH
   a_occ_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(occ_ff))
      else $error("occupancy out of step with valid bits");

   a_insert_into_free: assert property (@(posedge clock) disable iff (reset)
      cmd.set_valid |-> (free_ff && !valid_ff[free_slot_ff] && occ_lt_cap))
      else $error("insert without a free slot");

   a_rsp_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (rsp_free && !sts.is_put))
      else $error("response loaded over a waiting word");

   a_rsp_shown: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> (rsp_valid_ff && (found_ff == $past(hit_ff))))
      else $error("loaded response not presented");

   a_evict_has_victim: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_key && (cmd.slot_sel == SEL_LRU)) |-> (lru_ff && valid_ff[lru_slot_ff]))
      else $error("eviction without a resident victim");
`endif

endmodule

`default_nettype wire
